@@ rtl/core/pfr_pkg.sv @@
package pfr_pkg;

    // Request kinds.
    localparam logic [1:0] K_ACCESS  = 2'd0;
    localparam logic [1:0] K_GROUP   = 2'd1;
    localparam logic [1:0] K_PROCESS = 2'd2;

    // Replacement policies.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SC   = 2'd1;
    localparam logic [1:0] POL_LRU  = 2'd2;
    localparam logic [1:0] POL_LFU  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_PENALTY = 1'b1;

    localparam logic [31:0] MARK_MAX = 32'hFFFF_FFFF;

    // What each cell offers to the search chain.
    typedef enum logic [2:0] {
        M_PAGE  = 3'd0,
        M_FREE  = 3'd1,
        M_STAMP = 3'd2,
        M_MARK  = 3'd3,
        M_GROUP = 3'd4,
        M_PROC  = 3'd5
    } pfr_mode_t;

    // State updates broadcast to the cells.
    typedef enum logic [2:0] {
        C_NONE    = 3'd0,
        C_HIT     = 3'd1,
        C_RESTAMP = 3'd2,
        C_WRITE   = 3'd3,
        C_RELEASE = 3'd4
    } pfr_cmd_t;

    typedef struct packed {
        pfr_mode_t   mode;
        pfr_cmd_t    cmd;
        logic [1:0]  policy;
        logic [15:0] page;
        logic [15:0] group;
        logic [7:0]  proc;
        logic [31:0] recency;
        logic [31:0] order;
    } pfr_ctl_t;

endpackage

@@ rtl/core/pfr_cell.sv @@
module pfr_cell
    import pfr_pkg::*;
#(
    parameter int IW    = 7,
    parameter int CW    = 8,
    parameter int INDEX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pfr_ctl_t      ctl,
    input  logic [IW-1:0] target,
    input  logic          in_found,
    input  logic [IW-1:0] in_idx,
    input  logic [31:0]   in_val,
    input  logic [31:0]   in_mark,
    input  logic [15:0]   in_page,
    input  logic [CW-1:0] in_cnt,
    output logic          out_found,
    output logic [IW-1:0] out_idx,
    output logic [31:0]   out_val,
    output logic [31:0]   out_mark,
    output logic [15:0]   out_page,
    output logic [CW-1:0] out_cnt
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic        valid_reg, valid_next;
    logic [15:0] page_reg, page_next;
    logic [15:0] group_reg, group_next;
    logic [7:0]  proc_reg, proc_next;
    logic [31:0] mark_reg, mark_next;
    logic [31:0] stamp_reg, stamp_next;

    logic          found_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0]   val_reg;
    logic [31:0]   lmark_reg;
    logic [15:0]   lpage_reg;
    logic [CW-1:0] cnt_reg;

    logic        key_ok;
    logic        use_val;
    logic [31:0] key_val;
    logic        take;
    logic        sel;

    always_comb
    begin
        key_ok  = 1'b0;
        use_val = 1'b0;
        key_val = stamp_reg;
        case (ctl.mode)
            M_PAGE:  key_ok = valid_reg && (page_reg == ctl.page);
            M_FREE:  key_ok = !valid_reg;
            M_STAMP:
            begin
                key_ok  = valid_reg;
                use_val = 1'b1;
            end
            M_MARK:
            begin
                key_ok  = valid_reg;
                use_val = 1'b1;
                key_val = mark_reg;
            end
            M_GROUP: key_ok = valid_reg && (group_reg == ctl.group);
            M_PROC:  key_ok = valid_reg && (proc_reg == ctl.proc);
            default: key_ok = 1'b0;
        endcase
        take = key_ok && (!in_found || (use_val && (key_val < in_val)));
    end

    // The search result moves one cell further along the row every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            found_reg <= in_found | key_ok;
            cnt_reg   <= in_cnt + {{(CW-1){1'b0}}, key_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= take ? MY_IDX : in_idx;
        val_reg   <= take ? key_val : in_val;
        lmark_reg <= take ? mark_reg : in_mark;
        lpage_reg <= take ? page_reg : in_page;
    end

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        group_next = group_reg;
        proc_next  = proc_reg;
        mark_next  = mark_reg;
        stamp_next = stamp_reg;
        sel        = (target == MY_IDX);
        case (ctl.cmd)
            C_HIT:
            begin
                if (sel)
                begin
                    case (ctl.policy)
                        POL_SC:  mark_next = 32'd1;
                        POL_LRU: mark_next = ctl.recency;
                        POL_LFU:
                        begin
                            if (mark_reg != MARK_MAX)
                            begin
                                mark_next = mark_reg + 32'd1;
                            end
                        end
                        default: mark_next = mark_reg;
                    endcase
                end
            end
            C_RESTAMP:
            begin
                if (sel)
                begin
                    mark_next  = 32'd0;
                    stamp_next = ctl.order;
                end
            end
            C_WRITE:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    page_next  = ctl.page;
                    group_next = ctl.group;
                    proc_next  = ctl.proc;
                    stamp_next = ctl.order;
                    if (ctl.policy == POL_LRU)
                    begin
                        mark_next = ctl.recency;
                    end
                    else if (ctl.policy == POL_LFU)
                    begin
                        mark_next = 32'd1;
                    end
                    else
                    begin
                        mark_next = 32'd0;
                    end
                end
            end
            C_RELEASE:
            begin
                if (key_ok)
                begin
                    valid_next = 1'b0;
                end
            end
            default: valid_next = valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        group_reg <= group_next;
        proc_reg  <= proc_next;
        mark_reg  <= mark_next;
        stamp_reg <= stamp_next;
    end

    assign out_found = found_reg;
    assign out_idx   = idx_reg;
    assign out_val   = val_reg;
    assign out_mark  = lmark_reg;
    assign out_page  = lpage_reg;
    assign out_cnt   = cnt_reg;

endmodule

@@ rtl/core/pfr_chain.sv @@
module pfr_chain
    import pfr_pkg::*;
#(
    parameter int FRAMES = 128,
    parameter int IW     = 7,
    parameter int CW     = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pfr_ctl_t      ctl,
    input  logic [IW-1:0] target,
    output logic          tail_found,
    output logic [IW-1:0] tail_idx,
    output logic [31:0]   tail_mark,
    output logic [15:0]   tail_page,
    output logic [CW-1:0] tail_cnt
);

    logic          lk_found [0:FRAMES];
    logic [IW-1:0] lk_idx   [0:FRAMES];
    logic [31:0]   lk_val   [0:FRAMES];
    logic [31:0]   lk_mark  [0:FRAMES];
    logic [15:0]   lk_page  [0:FRAMES];
    logic [CW-1:0] lk_cnt   [0:FRAMES];

    assign lk_found[0] = 1'b0;
    assign lk_idx[0]   = '0;
    assign lk_val[0]   = '0;
    assign lk_mark[0]  = '0;
    assign lk_page[0]  = '0;
    assign lk_cnt[0]   = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        pfr_cell #(
            .IW    (IW),
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .target    (target),
            .in_found  (lk_found[i]),
            .in_idx    (lk_idx[i]),
            .in_val    (lk_val[i]),
            .in_mark   (lk_mark[i]),
            .in_page   (lk_page[i]),
            .in_cnt    (lk_cnt[i]),
            .out_found (lk_found[i+1]),
            .out_idx   (lk_idx[i+1]),
            .out_val   (lk_val[i+1]),
            .out_mark  (lk_mark[i+1]),
            .out_page  (lk_page[i+1]),
            .out_cnt   (lk_cnt[i+1])
        );
    end

    assign tail_found = lk_found[FRAMES];
    assign tail_idx   = lk_idx[FRAMES];
    assign tail_mark  = lk_mark[FRAMES];
    assign tail_page  = lk_page[FRAMES];
    assign tail_cnt   = lk_cnt[FRAMES];

endmodule

@@ rtl/core/page_frame_replacement.sv @@
// Page frame table with FIFO, second-chance, LRU and LFU replacement.
// Input words (kind, page_id, group_id, process_id) arrive on a valid/ready
// channel; each one yields exactly one result word on the output valid/ready
// channel. Policy and miss penalty are written over the APB port; the user
// must write them only while idle, as the block itself does not enforce it.
// The frames live in a row of cells. Every question asked of the table (is
// the page resident, which frame is lowest free, which frame holds the
// smallest stamp or mark, how many frames belong to a group or process) is
// answered by a search result that ripples through the row one cell per
// cycle. A hit or a release takes one pass, a miss into a free frame two, a
// miss with eviction two; second chance adds one pass for each referenced
// frame it restamps (at most FRAMES). One word is in work at a time, and the
// next is taken as soon as the result is in the output register.
// Reset empties every frame, clears clocks and totals, and restores the
// policy to FIFO and the miss penalty to 5. A stalled receiver holds the
// result in the output register; the block then takes one more word, runs
// that word's first search pass and waits at its end until the register
// frees up.
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] page_id,
    input  logic [15:0] group_id,
    input  logic [7:0]  process_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [6:0]  frame,
    output logic        evicted,
    output logic [15:0] evicted_page,
    output logic [7:0]  freed_count,
    output logic [31:0] miss_total,
    output logic [39:0] time_total
);

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int WW  = $clog2(FRAMES + 3);
    localparam logic [WW-1:0] PASS_END = WW'(FRAMES + 2);
    localparam logic [CW-1:0] FULL     = CW'(FRAMES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_NOP  = 6'b000010,
        S_LOOK = 6'b000100,
        S_FREE = 6'b001000,
        S_VICT = 6'b010000,
        S_REL  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [WW-1:0] wait_reg, wait_next;
    pfr_ctl_t      ctl_reg, ctl_next;
    logic [IW-1:0] target_reg, target_next;

    logic [1:0]    policy_reg;
    logic [7:0]    penalty_reg;
    logic [31:0]   recency_reg, recency_next;
    logic [31:0]   order_reg, order_next;
    logic [CW-1:0] used_reg, used_next;
    logic [31:0]   miss_reg, miss_next;
    logic [39:0]   time_reg, time_next;

    logic          out_valid_reg, out_valid_next;
    logic          hit_reg, hit_next;
    logic [6:0]    frame_reg, frame_next;
    logic          evicted_reg, evicted_next;
    logic [15:0]   evpage_reg, evpage_next;
    logic [7:0]    freed_reg, freed_next;

    logic          tail_found;
    logic [IW-1:0] tail_idx;
    logic [31:0]   tail_mark;
    logic [15:0]   tail_page;
    logic [CW-1:0] tail_cnt;

    logic          emit_ok;
    logic          pass_done;
    logic          cfg_write;
    logic [IW+6:0] frame_wide;
    logic [CW+7:0] freed_wide;

    pfr_chain #(
        .FRAMES (FRAMES),
        .IW     (IW),
        .CW     (CW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_reg),
        .target     (target_reg),
        .tail_found (tail_found),
        .tail_idx   (tail_idx),
        .tail_mark  (tail_mark),
        .tail_page  (tail_page),
        .tail_cnt   (tail_cnt)
    );

    // Configuration port: zero-wait APB, word-aligned registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_POLICY:  prdata = {30'd0, policy_reg};
                REG_PENALTY: prdata = {24'd0, penalty_reg};
                default:     prdata = 32'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FIFO;
            penalty_reg <= 8'd5;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_POLICY:  policy_reg  <= pwdata[1:0];
                REG_PENALTY: penalty_reg <= pwdata[7:0];
                default:     policy_reg  <= policy_reg;
            endcase
        end
    end

    // The result register is free, or its word leaves at this edge.
    assign emit_ok    = !out_valid_reg || out_ready;
    // The tail of the row holds the answer once a full pass has gone by.
    assign pass_done  = (wait_reg == PASS_END) && emit_ok;
    assign frame_wide = {7'd0, tail_idx};
    assign freed_wide = {8'd0, tail_cnt};
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        wait_next      = (wait_reg == PASS_END) ? wait_reg : wait_reg + 1'b1;
        ctl_next       = ctl_reg;
        ctl_next.cmd   = C_NONE;
        target_next    = target_reg;
        recency_next   = recency_reg;
        order_next     = order_reg;
        used_next      = used_reg;
        miss_next      = miss_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        frame_next     = frame_reg;
        evicted_next   = evicted_reg;
        evpage_next    = evpage_reg;
        freed_next     = freed_reg;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl_next.page   = page_id;
                    ctl_next.group  = group_id;
                    ctl_next.proc   = process_id;
                    ctl_next.policy = policy_reg;
                    wait_next       = '0;
                    case (kind)
                        K_ACCESS:
                        begin
                            ctl_next.mode = M_PAGE;
                            state_next    = S_LOOK;
                        end
                        K_GROUP:
                        begin
                            ctl_next.mode = M_GROUP;
                            state_next    = S_REL;
                        end
                        K_PROCESS:
                        begin
                            ctl_next.mode = M_PROC;
                            state_next    = S_REL;
                        end
                        default: state_next = S_NOP;
                    endcase
                end
            end
            S_NOP:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    frame_next     = 7'd0;
                    evicted_next   = 1'b0;
                    evpage_next    = 16'd0;
                    freed_next     = 8'd0;
                    state_next     = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (pass_done)
                begin
                    if (tail_found)
                    begin
                        ctl_next.cmd     = C_HIT;
                        ctl_next.recency = recency_reg;
                        target_next      = tail_idx;
                        if (ctl_reg.policy == POL_LRU)
                        begin
                            recency_next = recency_reg + 32'd1;
                        end
                        time_next      = time_reg + 40'd1;
                        out_valid_next = 1'b1;
                        hit_next       = 1'b1;
                        frame_next     = frame_wide[6:0];
                        evicted_next   = 1'b0;
                        evpage_next    = 16'd0;
                        freed_next     = 8'd0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        miss_next = miss_reg + 32'd1;
                        time_next = time_reg + {32'd0, penalty_reg};
                        wait_next = '0;
                        if (used_reg != FULL)
                        begin
                            ctl_next.mode = M_FREE;
                            state_next    = S_FREE;
                        end
                        else
                        begin
                            ctl_next.mode = (ctl_reg.policy == POL_LRU ||
                                             ctl_reg.policy == POL_LFU) ? M_MARK : M_STAMP;
                            state_next    = S_VICT;
                        end
                    end
                end
            end
            S_FREE, S_VICT:
            begin
                if (pass_done)
                begin
                    target_next    = tail_idx;
                    ctl_next.order = order_reg;
                    order_next     = order_reg + 32'd1;
                    if (state_reg == S_VICT && ctl_reg.policy == POL_SC && tail_mark != 32'd0)
                    begin
                        // Referenced frame: clear its mark, move it to the back and search again.
                        ctl_next.cmd = C_RESTAMP;
                        wait_next    = '0;
                    end
                    else
                    begin
                        ctl_next.cmd     = C_WRITE;
                        ctl_next.recency = recency_reg;
                        if (ctl_reg.policy == POL_LRU)
                        begin
                            recency_next = recency_reg + 32'd1;
                        end
                        if (state_reg == S_FREE)
                        begin
                            used_next    = used_reg + 1'b1;
                            evicted_next = 1'b0;
                            evpage_next  = 16'd0;
                        end
                        else
                        begin
                            evicted_next = 1'b1;
                            evpage_next  = tail_page;
                        end
                        out_valid_next = 1'b1;
                        hit_next       = 1'b0;
                        frame_next     = frame_wide[6:0];
                        freed_next     = 8'd0;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_REL:
            begin
                if (pass_done)
                begin
                    ctl_next.cmd   = C_RELEASE;
                    used_next      = used_reg - tail_cnt;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    frame_next     = 7'd0;
                    evicted_next   = 1'b0;
                    evpage_next    = 16'd0;
                    freed_next     = freed_wide[7:0];
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            ctl_reg       <= '{mode: M_PAGE, cmd: C_NONE, default: '0};
            target_reg    <= '0;
            recency_reg   <= 32'd0;
            order_reg     <= 32'd0;
            used_reg      <= '0;
            miss_reg      <= 32'd0;
            time_reg      <= 40'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            ctl_reg       <= ctl_next;
            target_reg    <= target_next;
            recency_reg   <= recency_next;
            order_reg     <= order_next;
            used_reg      <= used_next;
            miss_reg      <= miss_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        frame_reg   <= frame_next;
        evicted_reg <= evicted_next;
        evpage_reg  <= evpage_next;
        freed_reg   <= freed_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign frame        = frame_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evpage_reg;
    assign freed_count  = freed_reg;
    assign miss_total   = miss_reg;
    assign time_total   = time_reg;

    // The sequencer is always in exactly one state.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // The occupancy count never exceeds the number of frames.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL)
        else $error("used frame count above frame count");

    // A table update is a single-cycle strobe.
    a_cmd_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.cmd != C_NONE |=> ctl_reg.cmd == C_NONE)
        else $error("table update held for more than one cycle");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hit_reg |-> !evicted_reg)
        else $error("hit result reports an eviction");

endmodule
